// ===== rtl/nfe_pkg.sv =====
// Shared constants and register map for the neural field Euler step unit.
`timescale 1ns / 1ps
`default_nettype none

package nfe_pkg;

    localparam int ACT_W = 16;
    localparam int SIG_W = 16;
    localparam int IDX_W = 8;
    localparam int FSIZE_W = 9;
    localparam int RATE_W = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam int OUT_DATA_W = 40;
    localparam int OUT_SIG_LSB = ACT_W;
    localparam int OUT_IDX_LSB = ACT_W + SIG_W;

    localparam logic [FSIZE_W-1:0] FIELD_SIZE_RESET = 9'd256;
    localparam logic [RATE_W-1:0] STEP_RATE_RESET = 16'd6554;

    typedef enum logic {
        REG_FIELD_SIZE = 1'b0,
        REG_STEP_RATE  = 1'b1
    } t_reg_sel;

endpackage

`default_nettype wire

// ===== rtl/nfe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module nfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/neural_field_euler_step_unit.sv =====
// Top level of the one-dimensional neural field Euler step unit.
//
//  Channel   | Direction | Signals                              | Contents
//  ----------+-----------+--------------------------------------+---------------------------
//  s_axis    | in        | tvalid, tready, tdata[15:0], tuser   | input_value; tuser = mode
//  m_axis    | out       | tvalid, tready, tdata[39:0], tlast   | activation, sigmoid, index
//  APB       | in/out    | psel, penable, pwrite, paddr, pwdata | field_size, step_rate
//
// One request is accepted every cycle unless the output stalls, then passes stages A to C.
// The three stages are the store read, the Euler update with its multiplier,
// and the sigmoid index multiply with its table lookup.
// After reset the unit accepts requests at once: a fill count marks which store
// entries were written, and unwritten entries read as zero.
// A stalled output back-pressures the stages one by one, so no request is lost.
`timescale 1ns / 1ps
`default_nettype none

module neural_field_euler_step_unit #(
    parameter int MAX_ELEMENTS = 256,
    parameter int SIGMOID_ENTRIES = 256
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [15:0]                       s_axis_tdata,  // [15:0] input_value
    input  wire                               s_axis_tuser,  // [0] mode
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [15:0] activation_out, [31:16] field_output, [39:32] element_index
    output logic [nfe_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [nfe_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire  [nfe_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [nfe_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int PW = $clog2(MAX_ELEMENTS);
    localparam int SW = $clog2(MAX_ELEMENTS + 1);
    localparam int CW = (SW > nfe_pkg::FSIZE_W) ? SW : nfe_pkg::FSIZE_W;
    localparam int IW = $clog2(SIGMOID_ENTRIES);
    localparam int NW = $clog2(SIGMOID_ENTRIES + 1);

    function automatic logic [15:0] sig_entry(input int i);
        int mid;
        int ax;
        int y;
        mid = ((2 * i + 1) * 65536) / (2 * SIGMOID_ENTRIES) - 32768;
        ax = (mid < 0) ? -mid : mid;
        if (ax < 256) begin
            y = 32768 + 64 * ax;
        end else if (ax < 608) begin
            y = 40960 + 32 * ax;
        end else if (ax < 1280) begin
            y = 55296 + 8 * ax;
        end else begin
            y = 65536;
        end
        if (mid < 0) begin
            y = 65536 - y;
        end
        if (y > 65535) begin
            y = 65535;
        end
        return 16'(y);
    endfunction

    logic [15:0] w_sig_rom [SIGMOID_ENTRIES];

    for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_sig_rom
        assign w_sig_rom[g] = sig_entry(g);
    end

    // Configuration registers.
    logic [nfe_pkg::FSIZE_W-1:0] r_field_size;
    logic [nfe_pkg::RATE_W-1:0]  r_step_rate;
    logic                        w_cfg_write;

    assign pready = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_size <= nfe_pkg::FIELD_SIZE_RESET;
            r_step_rate <= nfe_pkg::STEP_RATE_RESET;
        end else if (w_cfg_write) begin
            unique case (nfe_pkg::t_reg_sel'(paddr[2]))
                nfe_pkg::REG_FIELD_SIZE: r_field_size <= pwdata[nfe_pkg::FSIZE_W-1:0];
                nfe_pkg::REG_STEP_RATE:  r_step_rate <= pwdata[nfe_pkg::RATE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (nfe_pkg::t_reg_sel'(paddr[2]))
            nfe_pkg::REG_FIELD_SIZE: prdata = nfe_pkg::APB_DATA_W'(r_field_size);
            nfe_pkg::REG_STEP_RATE:  prdata = nfe_pkg::APB_DATA_W'(r_step_rate);
        endcase
    end

    // Pipeline control.
    logic r_a_vld;
    logic r_b_vld;
    logic r_o_vld;
    logic w_accept;
    logic w_adv_a;
    logic w_adv_b;

    assign w_adv_b = r_b_vld && (!r_o_vld || m_axis_tready);
    assign w_adv_a = r_a_vld && (!r_b_vld || w_adv_b);
    assign s_axis_tready = !r_a_vld || w_adv_a;
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Position counter and effective field size.
    logic [CW-1:0] w_fs_ext;
    logic [SW-1:0] w_size;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;
    logic [SW-1:0] w_pos_ext;
    logic          w_last;
    logic [SW-1:0] r_fill;

    assign w_fs_ext = CW'(r_field_size);

    always_comb begin
        if (w_fs_ext < CW'(3)) begin
            w_size = SW'(3);
        end else if (w_fs_ext > CW'(MAX_ELEMENTS)) begin
            w_size = SW'(MAX_ELEMENTS);
        end else begin
            w_size = w_fs_ext[SW-1:0];
        end
        n_pos = (SW'(r_pos) >= w_size) ? '0 : r_pos;
        w_pos_ext = SW'(n_pos);
        w_last = (w_pos_ext + SW'(1)) >= w_size;
    end

    // Stage A: request register and store read.
    logic              r_a_mode;
    logic signed [15:0] r_a_x;
    logic [PW-1:0]     r_a_pos;
    logic              r_a_last;
    logic              r_a_written;
    logic [15:0]       w_ram_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_pos <= '0;
            r_fill <= '0;
        end else begin
            if (w_accept) begin
                r_a_vld <= 1'b1;
                r_pos <= w_last ? '0 : PW'(w_pos_ext + SW'(1));
                if (w_pos_ext >= r_fill) begin
                    r_fill <= w_pos_ext + SW'(1);
                end
            end else if (w_adv_a) begin
                r_a_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_mode <= s_axis_tuser;
            r_a_x <= s_axis_tdata;
            r_a_pos <= n_pos;
            r_a_last <= w_last;
            r_a_written <= w_pos_ext < r_fill;
        end
    end

    // Elements 0 to 2 and the saved old values live in registers.
    logic signed [15:0] r_el0;
    logic signed [15:0] r_el1;
    logic signed [15:0] r_el2;
    logic signed [15:0] r_old_first;
    logic signed [15:0] r_old_second;

    logic signed [15:0] w_a_old;
    logic signed [17:0] w_k;
    logic signed [19:0] w_d;
    logic signed [16:0] w_dt;
    logic signed [36:0] w_prod;
    logic signed [37:0] w_s;
    logic signed [21:0] w_q;
    logic signed [15:0] n_act;

    always_comb begin
        if (r_a_pos == PW'(0)) begin
            w_a_old = r_el0;
            w_k = 18'(r_el0) + 18'(r_el1);
        end else if (r_a_pos == PW'(1)) begin
            w_a_old = r_el1;
            w_k = 18'(r_old_first) + 18'(r_el1) + 18'(r_el2);
        end else if (r_a_pos == PW'(2)) begin
            w_a_old = r_el2;
            w_k = 18'(r_old_second) + 18'(r_el2);
        end else begin
            w_a_old = r_a_written ? w_ram_q : '0;
            w_k = '0;
        end
        w_dt = {1'b0, r_step_rate};
        w_d = 20'(r_a_x) - (20'(w_a_old) <<< 1) + 20'(w_k);
        w_prod = w_dt * w_d;
        w_s = {{6{w_a_old[15]}}, w_a_old, 16'b0} + 38'(w_prod) + 38'sd32768;
        w_q = w_s[37:16];
        if (r_a_mode) begin
            n_act = r_a_x;
        end else if (w_q > 22'sd32767) begin
            n_act = 16'sh7fff;
        end else if (w_q < -22'sd32768) begin
            n_act = 16'sh8000;
        end else begin
            n_act = w_q[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_el0 <= '0;
            r_el1 <= '0;
            r_el2 <= '0;
            r_old_first <= '0;
            r_old_second <= '0;
        end else if (w_adv_a) begin
            if (r_a_pos == PW'(0)) begin
                r_el0 <= n_act;
                r_old_first <= w_a_old;
            end
            if (r_a_pos == PW'(1)) begin
                r_el1 <= n_act;
                r_old_second <= w_a_old;
            end
            if (r_a_pos == PW'(2)) begin
                r_el2 <= n_act;
            end
        end
    end

    nfe_ram #(
        .WIDTH (16),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_adv_a),
        .i_waddr (r_a_pos),
        .i_wdata (n_act),
        .i_re    (w_accept),
        .i_raddr (n_pos),
        .o_rdata (w_ram_q)
    );

    // Stage B: new activation.
    logic signed [15:0] r_b_act;
    logic [PW-1:0]      r_b_pos;
    logic               r_b_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_adv_a) begin
            r_b_vld <= 1'b1;
        end else if (w_adv_b) begin
            r_b_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_a) begin
            r_b_act <= n_act;
            r_b_pos <= r_a_pos;
            r_b_last <= r_a_last;
        end
    end

    // Stage C: sigmoid lookup into the output register.
    logic [15:0]      w_biased;
    logic [16+NW-1:0] w_sig_prod;
    logic [IW-1:0]    w_sig_idx;
    logic [PW+7:0]    w_idx_ext;

    assign w_biased = {~r_b_act[15], r_b_act[14:0]};
    assign w_sig_prod = (16 + NW)'(w_biased) * (16 + NW)'(SIGMOID_ENTRIES);
    assign w_sig_idx = w_sig_prod[16 +: IW];
    assign w_idx_ext = (PW + 8)'(r_b_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv_b) begin
            r_o_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_b) begin
            m_axis_tdata <= {w_idx_ext[7:0], w_sig_rom[w_sig_idx], r_b_act};
            m_axis_tlast <= r_b_last;
        end
    end

    assign m_axis_tvalid = r_o_vld;

endmodule

`default_nettype wire

// ===== rtl/nfe_checker.sv =====
// Port-level assertions for the neural field Euler step unit, with their bind.
`timescale 1ns / 1ps
`default_nettype none

module nfe_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            s_axis_tvalid,
    input wire                            s_axis_tready,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [nfe_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input wire                            m_axis_tlast,
    input wire                            pready
);

    logic                       w_out_req;
    logic [nfe_pkg::IDX_W-1:0]  w_idx;
    logic [nfe_pkg::IDX_W-1:0]  r_prev_idx;
    logic                       r_prev_last;
    logic                       r_seen;

    assign w_out_req = m_axis_tvalid && m_axis_tready;
    assign w_idx = m_axis_tdata[nfe_pkg::OUT_IDX_LSB +: nfe_pkg::IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_prev_idx <= '0;
            r_prev_last <= 1'b0;
        end else if (w_out_req) begin
            r_seen <= 1'b1;
            r_prev_idx <= w_idx;
            r_prev_last <= m_axis_tlast;
        end
    end

    // The configuration port never waits.
    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

    // An empty output register means every stage can drain, so input is taken.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready while output is empty");

    // A stalled result holds its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A nonzero element index follows its predecessor within the same pass.
    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_req && (w_idx != '0) |->
            r_seen && !r_prev_last && (w_idx == nfe_pkg::IDX_W'(r_prev_idx + 1'b1)))
        else $error("element index out of order");

endmodule

bind neural_field_euler_step_unit nfe_checker u_nfe_checker (.*);

`default_nettype wire
